@@ rtl/core/pcme_pkg.sv @@
// shared constants for the palette color match engine
// request codes, field widths and reset values; no dependencies

package pcme_pkg;

    localparam int PCME_DEPTH      = 256;
    localparam int PCME_CNT_W      = 9;
    localparam int PCME_COMP_W     = 8;
    localparam int PCME_IDX_W      = 8;
    localparam int PCME_DIST_W     = 18;
    localparam int PCME_SQ_W       = 2 * PCME_COMP_W;
    localparam int PCME_COLOR_W    = 3 * PCME_COMP_W;
    localparam int PCME_S_DATA_W   = 40;
    localparam int PCME_M_DATA_W   = 32;
    localparam int PCME_REQ_W      = 2;

    localparam logic [PCME_CNT_W-1:0] PCME_CNT_RESET = 9'd256;

    localparam logic [PCME_REQ_W-1:0] REQ_WRITE   = 2'd0;
    localparam logic [PCME_REQ_W-1:0] REQ_CLOSEST = 2'd1;
    localparam logic [PCME_REQ_W-1:0] REQ_EXACT   = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

endpackage

@@ rtl/core/palette_color_match_engine.sv @@
// palette color match engine: palette store, entry scan pipeline, result register
// depends on pcme_pkg
//
//  channel   | dir | handshake              | content
//  s word    | in  | i_s_tvalid/o_s_tready  | tuser req_type, tdata entry/color/mark
//  m word    | out | o_m_tvalid/i_m_tready  | tuser match_found, tdata index/distance
//  cfg       | in  | i_cfg_we               | entry_count, taken at a clock edge while i_cfg_we is high
//
// a query scans n entries, where n is min(entry_count, PALETTE_DEPTH): one palette
// entry is read per cycle from the single-port store and fed through one
// squared-distance unit and one compare
// after reset the store is swept to zero with s tready low
// s tready is high only while idle; a finished result waits in the m register,
// the next word is taken while it waits, and a result waits for the m side to drain

module palette_color_match_engine
    import pcme_pkg::*;
#(
    parameter int PALETTE_DEPTH = PCME_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    // [7:0] entry_index, [15:8] red, [23:16] green, [31:24] blue, [32] used_mark
    input  logic [PCME_S_DATA_W-1:0] i_s_tdata,
    // [1:0] req_type
    input  logic [PCME_REQ_W-1:0]    i_s_tuser,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    // [7:0] match_index, [25:8] match_distance
    output logic [PCME_M_DATA_W-1:0] o_m_tdata,
    // [0] match_found
    output logic                     o_m_tuser,
    input  logic                     i_cfg_we,
    input  logic [PCME_CNT_W-1:0]    i_cfg_wdata
);

    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int NW = $clog2(PALETTE_DEPTH + 1);
    localparam int CW = (NW > PCME_CNT_W) ? NW : PCME_CNT_W;
    localparam int MW = PCME_COLOR_W + 1;

    // palette store: {used, red, green, blue}
    logic [MW-1:0] mem [PALETTE_DEPTH];

    t_state                  r_state;
    logic [PCME_CNT_W-1:0]   r_count;
    logic [AW-1:0]           r_addr;
    logic                    r_issuing;
    logic [NW-1:0]           r_n;
    logic [PCME_REQ_W-1:0]   r_req;
    logic [PCME_COMP_W-1:0]  r_q_r, r_q_g, r_q_b;
    logic [PCME_IDX_W-1:0]   r_wr_idx;
    logic                    r_wr_ok;

    logic [MW-1:0]           r_rd;
    logic                    r_v1, r_v2, r_v3;
    logic                    r_last1, r_last2, r_last3;
    logic [AW-1:0]           r_idx1, r_idx2, r_idx3;
    logic [PCME_SQ_W-1:0]    r_sq_r, r_sq_g, r_sq_b;
    logic                    r_eq2, r_eq3;
    logic [PCME_DIST_W-1:0]  r_sum3;

    logic                    r_have;
    logic [AW-1:0]           r_best;
    logic [PCME_DIST_W-1:0]  r_best_d;

    logic                    r_out_valid;
    logic [PCME_M_DATA_W-1:0] r_out_data;
    logic                    r_out_user;

    logic                    s_acc;
    logic [PCME_IDX_W-1:0]   in_idx;
    logic [PCME_COMP_W-1:0]  in_r, in_g, in_b;
    logic                    in_mark;
    logic                    wr_in_range;
    logic [NW-1:0]           scan_n;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [MW-1:0]           mem_wdata;
    logic                    rd_en;
    logic                    addr_last;
    logic [PCME_COMP_W-1:0]  d_r, d_g, d_b;
    logic                    better;
    logic                    out_load;
    logic [PCME_IDX_W-1:0]   res_idx;
    logic                    res_found;
    logic [PCME_DIST_W-1:0]  res_dist;

    assign in_idx  = i_s_tdata[7:0];
    assign in_r    = i_s_tdata[15:8];
    assign in_g    = i_s_tdata[23:16];
    assign in_b    = i_s_tdata[31:24];
    assign in_mark = i_s_tdata[32];

    assign o_s_tready  = (r_state == ST_IDLE);
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign wr_in_range = (32'(in_idx) < 32'(PALETTE_DEPTH));

    // entry_count above the palette saturates
    assign scan_n = (CW'(r_count) > CW'(PALETTE_DEPTH)) ? NW'(PALETTE_DEPTH)
                                                        : NW'(r_count);

    assign addr_last = ((NW'(r_addr) + NW'(1)) == r_n);
    assign rd_en     = (r_state == ST_SCAN) && r_issuing;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = '0;
        if (r_state == ST_CLEAR) begin
            mem_we = 1'b1;
        end else if (s_acc && i_s_tuser == REQ_WRITE && wr_in_range) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(in_idx);
            mem_wdata = {in_mark, in_r, in_g, in_b};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd <= mem[r_addr];
        end
    end

    // distance unit: abs differences and squares, then sum, then compare
    always_comb begin
        d_r = (r_q_r > r_rd[23:16]) ? (r_q_r - r_rd[23:16]) : (r_rd[23:16] - r_q_r);
        d_g = (r_q_g > r_rd[15:8])  ? (r_q_g - r_rd[15:8])  : (r_rd[15:8] - r_q_g);
        d_b = (r_q_b > r_rd[7:0])   ? (r_q_b - r_rd[7:0])   : (r_rd[7:0] - r_q_b);
    end

    always_comb begin
        if (r_req == REQ_CLOSEST) begin
            better = !r_have || (r_sum3 < r_best_d);
        end else begin
            better = !r_have && r_eq3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx1   <= r_addr;
        r_last1  <= addr_last;
        r_sq_r   <= PCME_SQ_W'(d_r) * PCME_SQ_W'(d_r);
        r_sq_g   <= PCME_SQ_W'(d_g) * PCME_SQ_W'(d_g);
        r_sq_b   <= PCME_SQ_W'(d_b) * PCME_SQ_W'(d_b);
        r_eq2    <= r_rd[MW-1] && (r_rd[PCME_COLOR_W-1:0] == {r_q_r, r_q_g, r_q_b});
        r_idx2   <= r_idx1;
        r_last2  <= r_last1;
        r_sum3   <= PCME_DIST_W'(r_sq_r) + PCME_DIST_W'(r_sq_g) + PCME_DIST_W'(r_sq_b);
        r_eq3    <= r_eq2;
        r_idx3   <= r_idx2;
        r_last3  <= r_last2;
        if (s_acc) begin
            r_req    <= i_s_tuser;
            r_q_r    <= in_r;
            r_q_g    <= in_g;
            r_q_b    <= in_b;
            r_wr_idx <= in_idx;
            r_wr_ok  <= wr_in_range;
            r_n      <= scan_n;
            r_have   <= 1'b0;
            r_best   <= '0;
            r_best_d <= '0;
        end else if (r_v3 && better) begin
            r_have   <= 1'b1;
            r_best   <= r_idx3;
            r_best_d <= r_sum3;
        end
    end

    always_comb begin
        res_idx   = '0;
        res_found = 1'b0;
        res_dist  = '0;
        case (r_req)
            REQ_WRITE: begin
                res_idx   = r_wr_idx;
                res_found = r_wr_ok;
            end
            REQ_CLOSEST: begin
                res_idx   = PCME_IDX_W'(r_best);
                res_found = r_have;
                res_dist  = r_best_d;
            end
            REQ_EXACT: begin
                res_idx   = r_have ? PCME_IDX_W'(r_best) : '0;
                res_found = r_have;
            end
            default: begin
                res_found = 1'b0;
            end
        endcase
    end

    assign out_load = (r_state == ST_DONE) && (!r_out_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {{(PCME_M_DATA_W - PCME_IDX_W - PCME_DIST_W){1'b0}}, res_dist, res_idx};
            r_out_user <= res_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_count     <= PCME_CNT_RESET;
            r_addr      <= '0;
            r_issuing   <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            r_v1 <= rd_en;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    if (r_addr == AW'(PALETTE_DEPTH - 1)) begin
                        r_addr  <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                ST_IDLE: begin
                    if (s_acc) begin
                        r_addr <= '0;
                        if ((i_s_tuser == REQ_CLOSEST || i_s_tuser == REQ_EXACT)
                                && scan_n != '0) begin
                            r_issuing <= 1'b1;
                            r_state   <= ST_SCAN;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_SCAN: begin
                    if (r_issuing) begin
                        if (addr_last) begin
                            r_issuing <= 1'b0;
                        end else begin
                            r_addr <= r_addr + AW'(1);
                        end
                    end
                    // last entry leaves the compare stage
                    if (r_v3 && r_last3) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result loaded outside done state");

    a_pipe_empty_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !(r_v1 || r_v2 || r_v3 || r_issuing))
        else $error("scan pipeline busy while idle");

    a_store_write_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == ST_CLEAR || r_state == ST_IDLE))
        else $error("palette written during a scan");

endmodule

@@ tb/palette_color_match_engine_tb.sv @@
// self-checking testbench for palette_color_match_engine: palette writes, closest and
// exact color searches and unknown request codes under several entry_count settings and random bus idling
// depends on pcme_pkg and the palette_color_match_engine rtl

module palette_color_match_engine_tb
    import pcme_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [PCME_REQ_W-1:0] REQ_UNKNOWN = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int NUM_PHASES     = 12;
    localparam int PHASE_ITEMS    = 134;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [PCME_IDX_W-1:0]  index;
        logic                   found;
        logic [PCME_DIST_W-1:0] distance;
    } match_t;

    // shadow palette and the queue of results still owed by the block
    class palette_scoreboard;
        logic [PCME_COLOR_W-1:0] palette_rgb [PCME_DEPTH];
        bit                      palette_used [PCME_DEPTH];
        logic [PCME_CNT_W-1:0]   entry_count;
        match_t                  pending_matches [$];
        int                      mismatches;
        int                      n_write;
        int                      n_closest;
        int                      n_exact;
        int                      n_exact_hit;
        int                      n_unknown;

        function new();
            foreach (palette_rgb[i]) begin
                palette_rgb[i]  = '0;
                palette_used[i] = 1'b0;
            end
            entry_count = PCME_CNT_RESET;
        endfunction

        function int scan_length();
            return (entry_count > PCME_DEPTH) ? PCME_DEPTH : int'(entry_count);
        endfunction

        function int unsigned color_distance(logic [PCME_COLOR_W-1:0] c,
                                             logic [7:0] r, logic [7:0] g, logic [7:0] b);
            int dr;
            int dg;
            int db;
            dr = int'(c[23:16]) - int'(r);
            dg = int'(c[15:8]) - int'(g);
            db = int'(c[7:0]) - int'(b);
            return dr * dr + dg * dg + db * db;
        endfunction

        function void note_request(logic [PCME_REQ_W-1:0] req, logic [7:0] idx,
                                   logic [7:0] r, logic [7:0] g, logic [7:0] b, logic mark);
            match_t      want;
            int unsigned d;
            int unsigned best_d;
            bit          have;
            want = '0;
            have = 1'b0;
            best_d = 0;
            case (req)
                REQ_WRITE: begin
                    n_write++;
                    palette_rgb[idx]  = {r, g, b};
                    palette_used[idx] = mark;
                    want.index = idx;
                    want.found = 1'b1;
                end
                REQ_CLOSEST: begin
                    n_closest++;
                    for (int i = 0; i < scan_length(); i++) begin
                        d = color_distance(palette_rgb[i], r, g, b);
                        // strict compare keeps the lowest index on a tie
                        if (!have || d < best_d) begin
                            have = 1'b1;
                            best_d = d;
                            want.index = i[7:0];
                        end
                    end
                    want.found = have;
                    want.distance = best_d[PCME_DIST_W-1:0];
                end
                REQ_EXACT: begin
                    n_exact++;
                    for (int i = 0; i < scan_length(); i++) begin
                        if (!want.found && palette_used[i] && palette_rgb[i] == {r, g, b}) begin
                            want.index = i[7:0];
                            want.found = 1'b1;
                        end
                    end
                    if (want.found)
                        n_exact_hit++;
                end
                default: n_unknown++;
            endcase
            pending_matches.push_back(want);
        endfunction

        function void check_match(match_t got);
            match_t want;
            if (pending_matches.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected word: index %0d found %0d distance %0d",
                             $realtime, got.index, got.found, got.distance);
            end else begin
                want = pending_matches.pop_front();
                if (got.index !== want.index || got.found !== want.found
                        || got.distance !== want.distance) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display(
                            "%0t: expected index %0d found %0d distance %0d, got %0d %0d %0d",
                            $realtime, want.index, want.found, want.distance,
                            got.index, got.found, got.distance);
                end
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_s_tvalid;
    logic                     o_s_tready;
    logic [PCME_S_DATA_W-1:0] i_s_tdata;
    logic [PCME_REQ_W-1:0]    i_s_tuser;
    logic                     o_m_tvalid;
    logic                     i_m_tready;
    logic [PCME_M_DATA_W-1:0] o_m_tdata;
    logic                     o_m_tuser;
    logic                     i_cfg_we;
    logic [PCME_CNT_W-1:0]    i_cfg_wdata;

    palette_scoreboard sb = new();
    int send_idle_pct = 24;
    int recv_idle_pct = 49;
    int idle_cycles   = 0;
    int cfg_writes    = 0;

    palette_color_match_engine i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        match_t got;
        bit     moved;
        moved = 1'b0;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            sb.note_request(i_s_tuser, i_s_tdata[7:0], i_s_tdata[15:8], i_s_tdata[23:16],
                            i_s_tdata[31:24], i_s_tdata[32]);
            moved = 1'b1;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{o_m_tdata[7:0], o_m_tuser, o_m_tdata[25:8]};
            sb.check_match(got);
            moved = 1'b1;
        end
        idle_cycles <= moved ? 0 : idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("%0t: no word moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_request(input logic [PCME_REQ_W-1:0] req, input logic [7:0] idx,
                                input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b, input logic mark);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {7'd0, mark, b, g, r, idx};
        i_s_tuser  <= req;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    // hold the sender off until every owed result has drained
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (sb.pending_matches.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_entry_count(input logic [PCME_CNT_W-1:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.entry_count = value;
        cfg_writes++;
        @(negedge i_clk);
    endtask

    task automatic send_random_request();
        int unsigned            pick;
        int                     span;
        logic [PCME_REQ_W-1:0]  req;
        logic [7:0]             idx;
        logic [PCME_COLOR_W-1:0] rgb;
        logic                   mark;
        pick = $urandom_range(0, 99);
        span = sb.scan_length();
        idx  = 8'($urandom_range(0, 255));
        rgb  = 24'($urandom);
        mark = ($urandom_range(0, 99) < 70);
        if ($urandom_range(0, 99) < 10) begin
            for (int k = 0; k < 3; k++)
                rgb[8*k +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end else if (span > 0 && $urandom_range(0, 99) < (pick >= 65 ? 70 : 30)) begin
            // reuse a stored color so searches hit, tie and land close
            rgb = sb.palette_rgb[$urandom_range(0, span - 1)];
            if (pick >= 35 && pick < 65 && $urandom_range(0, 1))
                rgb = rgb ^ (24'($urandom) & 24'h030303);
        end
        if (pick < 35) begin
            req = REQ_WRITE;
            if (span > 0 && $urandom_range(0, 99) < 75)
                idx = 8'($urandom_range(0, span - 1));
        end else if (pick < 65) begin
            req = REQ_CLOSEST;
        end else if (pick < 95) begin
            req = REQ_EXACT;
        end else begin
            req = REQ_UNKNOWN;
        end
        send_request(req, idx, rgb[23:16], rgb[15:8], rgb[7:0], mark);
    endtask

    initial begin
        logic [PCME_CNT_W-1:0] phase_count [NUM_PHASES];
        phase_count = '{9'd8, 9'd1, 9'd511, 9'd40, 9'd0, 9'd3,
                        9'd257, 9'd16, 9'd120, 9'd2, 9'd64, 9'd256};
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = REQ_WRITE;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty palette: farthest distance, and nothing used yet
        send_request(REQ_CLOSEST, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_request(REQ_EXACT,   8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        send_request(REQ_WRITE,   8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_request(REQ_WRITE,   8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
        send_request(REQ_EXACT,   8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        send_request(REQ_EXACT,   8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_request(REQ_CLOSEST, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        // unused duplicate: exact skips it, closest takes the lower index
        send_request(REQ_WRITE,   8'h0A, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_request(REQ_EXACT,   8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_request(REQ_CLOSEST, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_request(REQ_WRITE,   8'h05, 8'h12, 8'h34, 8'h56, 1'b1);
        send_request(REQ_WRITE,   8'h07, 8'h12, 8'h34, 8'h56, 1'b1);
        send_request(REQ_EXACT,   8'h00, 8'h12, 8'h34, 8'h56, 1'b0);
        send_request(REQ_WRITE,   8'h05, 8'h12, 8'h34, 8'h56, 1'b0);
        send_request(REQ_EXACT,   8'h00, 8'h12, 8'h34, 8'h56, 1'b0);
        send_request(REQ_UNKNOWN, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_request(REQ_WRITE,   8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        send_request(REQ_EXACT,   8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        send_request(REQ_WRITE,   8'h80, 8'h80, 8'h7F, 8'h01, 1'b1);
        send_request(REQ_CLOSEST, 8'h00, 8'h81, 8'h7E, 8'h00, 1'b0);

        // zero count scans nothing; one entry; count above the palette saturates
        write_entry_count(9'd0);
        send_request(REQ_CLOSEST, 8'h00, 8'h10, 8'h20, 8'h30, 1'b0);
        send_request(REQ_EXACT,   8'h00, 8'h12, 8'h34, 8'h56, 1'b0);
        write_entry_count(9'd1);
        send_request(REQ_CLOSEST, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        write_entry_count(9'd511);
        send_request(REQ_EXACT,   8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case ((phase * 3) / NUM_PHASES)
                0: begin
                    send_idle_pct = 24;
                    recv_idle_pct = 49;
                end
                1: begin
                    send_idle_pct = 49;
                    recv_idle_pct = 24;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_entry_count(phase_count[phase]);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random_request();
        end

        drain_results();
        repeat (16) @(posedge i_clk);
        $display(
            "covered %0d writes, %0d closest and %0d exact searches (%0d hits), %0d unknown",
            sb.n_write, sb.n_closest, sb.n_exact, sb.n_exact_hit, sb.n_unknown);
        $display("across %0d entry_count settings including 0, 1, 256 and 511; %0d mismatches",
                 cfg_writes, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_matches.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d results still owed", sb.pending_matches.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/pcme_pkg.sv
rtl/core/palette_color_match_engine.sv
tb/palette_color_match_engine_tb.sv
